### hdl/hdfe_pkg.sv
// ----------------------------------------------------------------------------
// hdfe_pkg
// Shared types and constants of the HID descriptor field extractor.
// ----------------------------------------------------------------------------
package hdfe_pkg;

	// Byte phase of the item assembler
	typedef enum logic [2:0] {
		PH_PREFIX,
		PH_DATA,
		PH_LSIZE,
		PH_LTAG,
		PH_LDATA
	} phase_t;

	localparam logic [7:0]  LONG_PREFIX  = 8'hFE;
	localparam logic [1:0]  TYPE_MAIN    = 2'd0;
	localparam logic [1:0]  TYPE_GLOBAL  = 2'd1;
	localparam logic [1:0]  TYPE_LOCAL   = 2'd2;
	localparam logic [3:0]  G_PAGE       = 4'd0;
	localparam logic [3:0]  G_LMIN       = 4'd1;
	localparam logic [3:0]  G_LMAX       = 4'd2;
	localparam logic [3:0]  G_RSIZE      = 4'd7;
	localparam logic [3:0]  G_RID        = 4'd8;
	localparam logic [3:0]  G_RCOUNT     = 4'd9;
	localparam logic [3:0]  L_USAGE      = 4'd0;
	localparam logic [3:0]  L_UMIN       = 4'd1;
	localparam logic [3:0]  L_UMAX       = 4'd2;
	localparam logic [3:0]  M_INPUT      = 4'd8;
	localparam logic [31:0] PAGE_DESKTOP = 32'h01;
	localparam logic [31:0] PAGE_BUTTON  = 32'h09;
	localparam logic [31:0] USAGE_HAT    = 32'h39;
	localparam logic [15:0] RID_BITS     = 16'd8;
	localparam logic [15:0] MAX_BITS     = 16'd32;

	localparam logic [1:0]  KIND_BUTTON  = 2'd0;
	localparam logic [1:0]  KIND_HAT     = 2'd1;
	localparam logic [1:0]  KIND_AXIS    = 2'd2;
	localparam logic [1:0]  KIND_END     = 2'd3;

	// One result record
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  rid;
		logic [15:0] off;
		logic [5:0]  size;
		logic [31:0] min;
		logic [31:0] max;
		logic [7:0]  ki;
		logic        uri;
		logic        ok;
		logic        last;
	} rec_t;

	// Controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic exec;
		logic rid_wr;
		logic latch_base;
		logic fld_eval;
		logic ofs_wb;
		logic emit_end;
		logic flush;
		logic clear;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic item_done;
		logic is_rid;
		logic is_input;
		logic loop_go;
		logic last_idx;
		logic fld_emit;
		logic pend_v;
		logic out_free;
		logic last;
	} sts_t;

endpackage

### hdl/hdfe_ram.sv
// ----------------------------------------------------------------------------
// hdfe_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module hdfe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                                 clk,
	input  logic                                 we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                     wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                     rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### hdl/hdfe_ctrl.sv
// ----------------------------------------------------------------------------
// hdfe_ctrl
// Sequencer: takes a byte, runs the finished item, expands Input fields.
// ----------------------------------------------------------------------------
module hdfe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  hdfe_pkg::sts_t st,
	output hdfe_pkg::cmd_t cmd
);
	import hdfe_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_RUN,
		S_RID_RD,
		S_RID_WR,
		S_MAIN_RD,
		S_MAIN_BASE,
		S_FLD_RD,
		S_FLD_EVAL,
		S_MAIN_WB,
		S_END,
		S_FLUSH
	} state_t;

	state_t state_q;
	state_t tail;
	logic   blocked;

	// Where to go once a byte's work is done
	always_comb begin
		priority if (st.last) begin
			tail = S_END;
		end else if (st.pend_v) begin
			tail = S_FLUSH;
		end else begin
			tail = S_IDLE;
		end
	end

	assign blocked  = st.pend_v && !st.out_free;
	assign in_stall = (state_q != S_IDLE);

	// Command decode
	always_comb begin
		cmd            = '0;
		cmd.load       = (state_q == S_IDLE) && in_valid;
		cmd.step       = (state_q == S_DECODE);
		cmd.exec       = (state_q == S_RUN);
		cmd.rid_wr     = (state_q == S_RID_WR);
		cmd.latch_base = (state_q == S_MAIN_BASE);
		cmd.fld_eval   = (state_q == S_FLD_EVAL) && !(st.fld_emit && blocked);
		cmd.ofs_wb     = (state_q == S_MAIN_WB);
		cmd.emit_end   = (state_q == S_END) && !blocked;
		cmd.flush      = (state_q == S_FLUSH) && st.out_free;
		cmd.clear      = cmd.flush && st.last;
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) state_q <= S_DECODE;
				end
				S_DECODE: begin
					state_q <= st.item_done ? S_RUN : tail;
				end
				S_RUN: begin
					priority if (st.is_rid) state_q <= S_RID_RD;
					else if (st.is_input) state_q <= S_MAIN_RD;
					else state_q <= tail;
				end
				S_RID_RD: state_q <= S_RID_WR;
				S_RID_WR: state_q <= tail;
				S_MAIN_RD: state_q <= S_MAIN_BASE;
				S_MAIN_BASE: begin
					state_q <= st.loop_go ? S_FLD_RD : S_MAIN_WB;
				end
				S_FLD_RD: state_q <= S_FLD_EVAL;
				S_FLD_EVAL: begin
					if (cmd.fld_eval) state_q <= st.last_idx ? S_MAIN_WB : S_FLD_RD;
				end
				S_MAIN_WB: state_q <= tail;
				S_END: begin
					if (cmd.emit_end) state_q <= S_FLUSH;
				end
				S_FLUSH: begin
					if (cmd.flush) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/hdfe_dp.sv
// ----------------------------------------------------------------------------
// hdfe_dp
// Datapath: item assembler, global and local state, offset and usage
// stores, field checks, record staging and output register.
// ----------------------------------------------------------------------------
module hdfe_dp #(
	parameter int MAX_FIELDS      = 32,
	parameter int MAX_BUTTONS     = 32,
	parameter int MAX_HATS        = 4,
	parameter int MAX_AXES        = 8,
	parameter int USAGE_SLOTS     = 32,
	parameter int REPORT_ID_SLOTS = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic [7:0]     desc_byte,
	input  logic           end_of_descriptor,
	input  logic           out_stall,
	output logic           out_valid,
	output hdfe_pkg::rec_t out_rec,
	input  hdfe_pkg::cmd_t cmd,
	output hdfe_pkg::sts_t st
);
	import hdfe_pkg::*;

	localparam int UAW = (USAGE_SLOTS > 1) ? $clog2(USAGE_SLOTS) : 1;
	localparam int ULW = $clog2(USAGE_SLOTS + 1);
	localparam int SAW = (REPORT_ID_SLOTS > 1) ? $clog2(REPORT_ID_SLOTS) : 1;

	// Byte assembler
	logic [7:0]  byte_q;
	logic        last_q;
	phase_t      phase_q;
	logic [7:0]  prefix_q;
	logic [31:0] acc_q;
	logic [8:0]  skip_q;
	// Global and local state
	logic [31:0] page_q, min_q, max_q;
	logic [15:0] size_q, count_q;
	logic [7:0]  id_q;
	logic [SAW-1:0] slot_q;
	logic        id_seen_q;
	logic [ULW-1:0] ulen_q;
	logic        rng_v_q;
	logic [31:0] rng_lo_q, rng_hi_q;
	logic [7:0]  nrec_q, nbtn_q, nhat_q, naxe_q;
	// Field loop
	logic [15:0] base_q, off_q, prod_q, idx_q;
	logic [REPORT_ID_SLOTS-1:0] ovld_q;
	logic        rd_vld_q;
	// Records
	rec_t        pend_q;
	logic        pend_v_q;
	rec_t        out_q;
	logic        out_valid_q;

	logic [SAW-1:0] slot_lut [256];
	logic [15:0] ofs_rd;
	logic [15:0] ofs_base;
	logic        ofs_we;
	logic [15:0] ofs_wd;
	logic [31:0] uram_rd;
	logic        uram_we;
	logic [UAW-1:0] uram_ra;

	// Report id to slot table
	for (genvar g = 0; g < 256; g++) begin : g_slot
		assign slot_lut[g] = SAW'(g % REPORT_ID_SLOTS);
	end

	// Item fields
	logic [2:0]  blen, plen;
	logic [1:0]  itype;
	logic [3:0]  itag;
	logic [31:0] sx, uval;
	logic [2:0]  didx;

	assign blen  = (byte_q[1:0] == 2'd3) ? 3'd4 : {1'b0, byte_q[1:0]};
	assign plen  = (prefix_q[1:0] == 2'd3) ? 3'd4 : {1'b0, prefix_q[1:0]};
	assign itype = prefix_q[3:2];
	assign itag  = prefix_q[7:4];
	assign didx  = plen - skip_q[2:0];

	// Sign extend from the item width
	always_comb begin
		unique case (prefix_q[1:0])
			2'd1:    sx = {{24{acc_q[7]}}, acc_q[7:0]};
			2'd2:    sx = {{16{acc_q[15]}}, acc_q[15:0]};
			default: sx = acc_q;
		endcase
	end

	// Usage value after a page override
	assign uval = (plen == 3'd4 && acc_q[31:16] != 16'd0) ? {16'd0, acc_q[15:0]} : acc_q;

	// Field checks for the current index
	logic        in_list;
	logic [31:0] rng_c, rng_u, usage;
	logic        take_btn, take_hat, take_axe, size_ok, fld_ok;
	rec_t        new_rec;

	assign in_list  = idx_q < 16'(ulen_q);
	assign rng_c    = rng_lo_q + 32'(idx_q);
	assign rng_u    = (rng_c <= rng_hi_q) ? rng_c : rng_hi_q;
	assign usage    = in_list ? uram_rd : rng_v_q ? rng_u : (ulen_q != '0) ? uram_rd : 32'd0;
	assign take_btn = (page_q == PAGE_BUTTON) && (nbtn_q < 8'(MAX_BUTTONS));
	assign take_hat = !take_btn && (page_q == PAGE_DESKTOP) && (usage == USAGE_HAT)
		&& (nhat_q < 8'(MAX_HATS));
	assign take_axe = !take_btn && !take_hat && (size_q > 16'd1) && (naxe_q < 8'(MAX_AXES));
	assign size_ok  = (size_q != 16'd0) && (size_q <= MAX_BITS) && (nrec_q < 8'(MAX_FIELDS));
	assign fld_ok   = (take_btn || take_hat || take_axe) && size_ok;

	// Build the record to stage
	always_comb begin
		new_rec      = '0;
		if (cmd.emit_end) begin
			new_rec.kind = KIND_END;
			new_rec.uri  = id_seen_q;
			new_rec.ok   = (nrec_q != 8'd0);
		end else begin
			new_rec.rid  = id_q;
			new_rec.off  = off_q;
			new_rec.size = size_q[5:0];
			new_rec.min  = min_q;
			new_rec.max  = max_q;
			priority if (take_btn) begin
				new_rec.kind = KIND_BUTTON;
				new_rec.ki   = nbtn_q;
			end else if (take_hat) begin
				new_rec.kind = KIND_HAT;
				new_rec.ki   = nhat_q;
			end else begin
				new_rec.kind = KIND_AXIS;
				new_rec.ki   = naxe_q;
			end
		end
	end

	// Offset store, one entry per report id slot
	assign ofs_base = rd_vld_q ? ofs_rd : 16'd0;
	assign ofs_we   = (cmd.rid_wr && ofs_base == 16'd0) || cmd.ofs_wb;
	assign ofs_wd   = cmd.ofs_wb ? 16'(base_q + prod_q) : RID_BITS;

	hdfe_ram #(.WIDTH(16), .DEPTH(REPORT_ID_SLOTS)) u_ofs (
		.clk   (clk),
		.we    (ofs_we),
		.waddr (slot_q),
		.wdata (ofs_wd),
		.raddr (slot_q),
		.rdata (ofs_rd)
	);

	// Usage list store
	assign uram_we = cmd.exec && itype == TYPE_LOCAL && itag == L_USAGE
		&& ulen_q < ULW'(USAGE_SLOTS);
	assign uram_ra = in_list ? idx_q[UAW-1:0] : UAW'(ulen_q - ULW'(1));

	hdfe_ram #(.WIDTH(32), .DEPTH(USAGE_SLOTS)) u_usage (
		.clk   (clk),
		.we    (uram_we),
		.waddr (ulen_q[UAW-1:0]),
		.wdata (uval),
		.raddr (uram_ra),
		.rdata (uram_rd)
	);

	// Status to the controller
	logic out_free;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		st           = '0;
		st.item_done = (phase_q == PH_PREFIX && byte_q != LONG_PREFIX && blen == 3'd0)
			|| (phase_q == PH_DATA && skip_q == 9'd1);
		st.is_rid    = itype == TYPE_GLOBAL && itag == G_RID;
		st.is_input  = itype == TYPE_MAIN && itag == M_INPUT;
		st.loop_go   = !acc_q[0] && acc_q[1] && count_q != 16'd0;
		st.last_idx  = idx_q == 16'(count_q - 16'd1);
		st.fld_emit  = fld_ok;
		st.pend_v    = pend_v_q;
		st.out_free  = out_free;
		st.last      = last_q;
	end

	// Input byte and assembler
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q   <= 1'b0;
			phase_q  <= PH_PREFIX;
			prefix_q <= 8'd0;
			acc_q    <= 32'd0;
			skip_q   <= 9'd0;
		end else if (cmd.clear) begin
			last_q   <= 1'b0;
			phase_q  <= PH_PREFIX;
			prefix_q <= 8'd0;
			acc_q    <= 32'd0;
			skip_q   <= 9'd0;
		end else if (cmd.load) begin
			last_q <= end_of_descriptor;
		end else if (cmd.step) begin
			unique case (phase_q)
				PH_PREFIX: begin
					if (byte_q == LONG_PREFIX) begin
						phase_q <= PH_LSIZE;
					end else begin
						prefix_q <= byte_q;
						acc_q    <= 32'd0;
						skip_q   <= 9'(blen);
						if (blen != 3'd0) phase_q <= PH_DATA;
					end
				end
				PH_DATA: begin
					unique case (didx[1:0])
						2'd0: acc_q[7:0]   <= byte_q;
						2'd1: acc_q[15:8]  <= byte_q;
						2'd2: acc_q[23:16] <= byte_q;
						2'd3: acc_q[31:24] <= byte_q;
					endcase
					skip_q <= skip_q - 9'd1;
					if (skip_q == 9'd1) phase_q <= PH_PREFIX;
				end
				PH_LSIZE: begin
					skip_q  <= {1'b0, byte_q};
					phase_q <= PH_LTAG;
				end
				PH_LTAG: begin
					phase_q <= (skip_q == 9'd0) ? PH_PREFIX : PH_LDATA;
				end
				PH_LDATA: begin
					if (skip_q != 9'd0) skip_q <= skip_q - 9'd1;
					if (skip_q <= 9'd1) phase_q <= PH_PREFIX;
				end
				default: phase_q <= PH_PREFIX;
			endcase
		end
	end

	// Hold the byte
	always_ff @(posedge clk) begin
		if (cmd.load) byte_q <= desc_byte;
	end

	// Global and local state, field counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q    <= 32'd0;
			min_q     <= 32'd0;
			max_q     <= 32'd1;
			size_q    <= 16'd0;
			count_q   <= 16'd0;
			id_q      <= 8'd0;
			slot_q    <= '0;
			id_seen_q <= 1'b0;
			ulen_q    <= '0;
			rng_v_q   <= 1'b0;
			rng_lo_q  <= 32'd0;
			rng_hi_q  <= 32'd0;
			nrec_q    <= 8'd0;
			nbtn_q    <= 8'd0;
			nhat_q    <= 8'd0;
			naxe_q    <= 8'd0;
			ovld_q    <= '0;
		end else if (cmd.clear) begin
			page_q    <= 32'd0;
			min_q     <= 32'd0;
			max_q     <= 32'd1;
			size_q    <= 16'd0;
			count_q   <= 16'd0;
			id_q      <= 8'd0;
			slot_q    <= '0;
			id_seen_q <= 1'b0;
			ulen_q    <= '0;
			rng_v_q   <= 1'b0;
			rng_lo_q  <= 32'd0;
			rng_hi_q  <= 32'd0;
			nrec_q    <= 8'd0;
			nbtn_q    <= 8'd0;
			nhat_q    <= 8'd0;
			naxe_q    <= 8'd0;
			ovld_q    <= '0;
		end else begin
			// Execute a global or local item, or drop locals after a main item other than Input
			if (cmd.exec) begin
				if (itype == TYPE_GLOBAL) begin
					unique case (itag)
						G_PAGE:   page_q <= acc_q;
						G_LMIN:   min_q  <= sx;
						G_LMAX:   max_q  <= min_q[31] ? sx : acc_q;
						G_RSIZE:  size_q <= acc_q[15:0];
						G_RCOUNT: count_q <= acc_q[15:0];
						G_RID: begin
							id_q      <= acc_q[7:0];
							slot_q    <= slot_lut[acc_q[7:0]];
							id_seen_q <= 1'b1;
						end
						default: ;
					endcase
				end else if (itype == TYPE_LOCAL) begin
					if (plen == 3'd4 && acc_q[31:16] != 16'd0) page_q <= {16'd0, acc_q[31:16]};
					if (uram_we) ulen_q <= ulen_q + ULW'(1);
					if (itag == L_UMIN) begin
						rng_lo_q <= uval;
						rng_v_q  <= 1'b1;
					end else if (itag == L_UMAX) begin
						rng_hi_q <= uval;
						rng_v_q  <= 1'b1;
					end
				end else if (itype == TYPE_MAIN && itag != M_INPUT) begin
					ulen_q   <= '0;
					rng_v_q  <= 1'b0;
					rng_lo_q <= 32'd0;
					rng_hi_q <= 32'd0;
				end
			end
			// Mark a slot written
			if (ofs_we) ovld_q[slot_q] <= 1'b1;
			// Advance kind counters, count recorded fields
			if (cmd.fld_eval) begin
				priority if (take_btn) nbtn_q <= nbtn_q + 8'd1;
				else if (take_hat) nhat_q <= nhat_q + 8'd1;
				else if (take_axe) naxe_q <= naxe_q + 8'd1;
				if (fld_ok) nrec_q <= nrec_q + 8'd1;
			end
			// Drop locals after an Input item
			if (cmd.ofs_wb) begin
				ulen_q   <= '0;
				rng_v_q  <= 1'b0;
				rng_lo_q <= 32'd0;
				rng_hi_q <= 32'd0;
			end
		end
	end

	// Field loop registers
	always_ff @(posedge clk) begin
		rd_vld_q <= ovld_q[slot_q];
		if (cmd.latch_base) begin
			base_q <= ofs_base;
			off_q  <= ofs_base;
			prod_q <= 16'(count_q * size_q);
			idx_q  <= 16'd0;
		end else if (cmd.fld_eval) begin
			off_q <= 16'(off_q + size_q);
			idx_q <= idx_q + 16'd1;
		end
	end

	// Stage records so the final one of a byte can be flagged
	logic emit;
	assign emit = (cmd.fld_eval && fld_ok) || cmd.emit_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			if (emit) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) out_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				pend_v_q    <= 1'b0;
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_q <= new_rec;
			if (pend_v_q) out_q <= pend_q;
		end else if (cmd.flush) begin
			out_q      <= pend_q;
			out_q.last <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_rec   = out_q;

endmodule

### hdl/hid_descriptor_field_extractor_core.sv
// ----------------------------------------------------------------------------
// hid_descriptor_field_extractor_core
// Parses a HID report descriptor byte by byte into field records.
// ----------------------------------------------------------------------------
// Input channel: desc_byte with end_of_descriptor, transferred on in_valid
// while in_stall is low. Output channel: one record per transfer on
// out_valid while out_stall is low; last_of_run flags the final record
// caused by a byte. The byte flagged end_of_descriptor yields an end record
// and then all parse state clears.
// A byte that completes no item is decoded only; a global or local item is
// also executed; a report id item then reads and writes the offset store;
// an Input item reads the offset store, latches the base and, for variable
// data, reads the usage store and checks a field per report count index,
// then writes the offset back. A byte that leaves records behind takes a
// flush step to release the last one; the final byte also stages and
// releases its end record. Records are staged one deep behind an output
// register; while the receiver stalls, field expansion waits and in_stall
// stays high. Reset clears all control state and the offset valid bits at
// once; the block can take a byte as soon as reset is released.
// ----------------------------------------------------------------------------
module hid_descriptor_field_extractor_core #(
	parameter int MAX_FIELDS      = 32,
	parameter int MAX_BUTTONS     = 32,
	parameter int MAX_HATS        = 4,
	parameter int MAX_AXES        = 8,
	parameter int USAGE_SLOTS     = 32,
	parameter int REPORT_ID_SLOTS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         desc_byte,
	input  logic               end_of_descriptor,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         rec_kind,
	output logic [7:0]         field_report_id,
	output logic [15:0]        field_bit_offset,
	output logic [5:0]         field_bit_size,
	output logic signed [31:0] field_min,
	output logic signed [31:0] field_max,
	output logic [7:0]         kind_index,
	output logic               uses_report_ids,
	output logic               parse_ok,
	output logic               last_of_run
);
	import hdfe_pkg::*;

	cmd_t cmd;
	sts_t st;
	rec_t rec;

	hdfe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	hdfe_dp #(
		.MAX_FIELDS      (MAX_FIELDS),
		.MAX_BUTTONS     (MAX_BUTTONS),
		.MAX_HATS        (MAX_HATS),
		.MAX_AXES        (MAX_AXES),
		.USAGE_SLOTS     (USAGE_SLOTS),
		.REPORT_ID_SLOTS (REPORT_ID_SLOTS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.desc_byte         (desc_byte),
		.end_of_descriptor (end_of_descriptor),
		.out_stall         (out_stall),
		.out_valid         (out_valid),
		.out_rec           (rec),
		.cmd               (cmd),
		.st                (st)
	);

	// Drive record fields
	assign rec_kind         = rec.kind;
	assign field_report_id  = rec.rid;
	assign field_bit_offset = rec.off;
	assign field_bit_size   = rec.size;
	assign field_min        = rec.min;
	assign field_max        = rec.max;
	assign kind_index       = rec.ki;
	assign uses_report_ids  = rec.uri;
	assign parse_ok         = rec.ok;
	assign last_of_run      = rec.last;

endmodule
